[sv/sorted_table_lookup_insert_core_macros.svh]
// Assertion helpers for the sorted table core.
`ifndef SORTED_TABLE_LOOKUP_INSERT_CORE_MACROS_SVH
`define SORTED_TABLE_LOOKUP_INSERT_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define STLI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define STLI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/stli_pkg.sv]
`default_nettype none

package stli_pkg;

    localparam int KEY_W       = 56;
    localparam int CLASS_W     = 8;
    localparam int QTY_W       = 20;
    localparam int COST_W      = 24;
    localparam int VALUE_W     = 44;
    localparam int STATUS_W    = 3;
    localparam int OUT_INDEX_W = 8;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND     = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_INSERTED  = 3'd2,
        ST_FULL      = 3'd3,
        ST_DUPLICATE = 3'd4
    } t_status;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SRCH  = 7'b0000010,
        S_CMP   = 7'b0000100,
        S_SHIFT = 7'b0001000,
        S_MOVE  = 7'b0010000,
        S_MUL   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [CLASS_W-1:0] cls;
        logic [QTY_W-1:0]   qty;
        logic [COST_W-1:0]  cost;
    } t_record;

endpackage

`default_nettype wire

[sv/sorted_table_lookup_insert_core.sv]
// Channel  | direction | handshake                | payload
// request  | in        | i_in_valid / o_in_stall  | op, part_key, part_class, quantity, cost
// result   | out       | o_out_valid / i_out_stall| status, index, class, quantity, cost, value
//
// Lookup: an accept step, then per probe an address step and a registered compare, up to
//   floor(log2(count))+1 probes, then a multiply on a hit or a range check on a miss.
// Insert: search; unless full or duplicate, a read and a write per entry moved up, then a
//   write of the new record; every request ends in an output step that waits out a stall.
// Reset (synchronous, active low) empties the table; record RAM is not cleared.
// Input stalls while a request is in work; a stalled result waits in the output register.
`default_nettype none

`include "sorted_table_lookup_insert_core_macros.svh"

module sorted_table_lookup_insert_core #(
    parameter int TABLE_DEPTH = 256,
    parameter int KEY_CHARS   = 7
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic                                i_op,
    input  wire logic [stli_pkg::KEY_W-1:0]          i_part_key,
    input  wire logic [stli_pkg::CLASS_W-1:0]        i_part_class,
    input  wire logic [stli_pkg::QTY_W-1:0]          i_quantity,
    input  wire logic [stli_pkg::COST_W-1:0]         i_cost_cents,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [stli_pkg::STATUS_W-1:0]            o_status,
    output logic [stli_pkg::OUT_INDEX_W-1:0]         o_found_index,
    output logic [stli_pkg::CLASS_W-1:0]             o_found_class,
    output logic [stli_pkg::QTY_W-1:0]               o_found_quantity,
    output logic [stli_pkg::COST_W-1:0]              o_found_cost_cents,
    output logic [stli_pkg::VALUE_W-1:0]             o_value_cents
);

    import stli_pkg::*;

    localparam int IDX_W    = $clog2(TABLE_DEPTH);
    localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_BITS = 8 * KEY_CHARS;
    localparam logic [KEY_W-1:0] KEY_MASK =
        (KEY_BITS >= KEY_W) ? {KEY_W{1'b1}} : ((KEY_W'(1) << KEY_BITS) - KEY_W'(1));

    // record RAM
    t_record r_mem [TABLE_DEPTH];
    t_record r_rd_data;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    logic [IDX_W-1:0] mem_ra;
    t_record          mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[mem_ra];
    end

    // control
    t_state r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_lo, n_lo;
    logic [CNT_W-1:0] r_hi, n_hi;
    logic [CNT_W-1:0] r_i, n_i;
    logic [CNT_W-1:0] r_pos, n_pos;
    logic [IDX_W-1:0] r_mid, n_mid;
    logic             r_out_valid, n_out_valid;

    // request payload
    logic               r_op, n_op;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [CLASS_W-1:0] r_class, n_class;
    logic [QTY_W-1:0]   r_qty, n_qty;
    logic [COST_W-1:0]  r_cost, n_cost;

    // result in work
    t_status            r_res_status, n_res_status;
    logic [IDX_W-1:0]   r_res_index, n_res_index;
    logic [CLASS_W-1:0] r_res_class, n_res_class;
    logic [QTY_W-1:0]   r_res_qty, n_res_qty;
    logic [COST_W-1:0]  r_res_cost, n_res_cost;
    logic [VALUE_W-1:0] r_res_value, n_res_value;

    // output register
    t_status            r_o_status, n_o_status;
    logic [IDX_W-1:0]   r_o_index, n_o_index;
    logic [CLASS_W-1:0] r_o_class, n_o_class;
    logic [QTY_W-1:0]   r_o_qty, n_o_qty;
    logic [COST_W-1:0]  r_o_cost, n_o_cost;
    logic [VALUE_W-1:0] r_o_value, n_o_value;

    logic [CNT_W-1:0]         w_mid;
    logic [CNT_W-1:0]         w_im1;
    logic [IDX_W+OUT_INDEX_W-1:0] w_idx_ext;

    assign w_mid = r_lo + ((r_hi - r_lo) >> 1);
    assign w_im1 = r_i - CNT_W'(1);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_i          = r_i;
        n_pos        = r_pos;
        n_mid        = r_mid;
        n_out_valid  = r_out_valid;
        n_op         = r_op;
        n_key        = r_key;
        n_class      = r_class;
        n_qty        = r_qty;
        n_cost       = r_cost;
        n_res_status = r_res_status;
        n_res_index  = r_res_index;
        n_res_class  = r_res_class;
        n_res_qty    = r_res_qty;
        n_res_cost   = r_res_cost;
        n_res_value  = r_res_value;
        n_o_status   = r_o_status;
        n_o_index    = r_o_index;
        n_o_class    = r_o_class;
        n_o_qty      = r_o_qty;
        n_o_cost     = r_o_cost;
        n_o_value    = r_o_value;
        mem_we       = 1'b0;
        mem_wa       = r_i[IDX_W-1:0];
        mem_ra       = w_mid[IDX_W-1:0];
        mem_wd       = r_rd_data;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_op;
                    n_key   = i_part_key & KEY_MASK;
                    n_class = i_part_class;
                    n_qty   = i_quantity;
                    n_cost  = i_cost_cents;
                    n_lo    = '0;
                    n_hi    = r_count;
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                n_res_index = '0;
                n_res_class = '0;
                n_res_qty   = '0;
                n_res_cost  = '0;
                n_res_value = '0;
                if (r_lo < r_hi) begin
                    n_mid   = w_mid[IDX_W-1:0];
                    n_state = S_CMP;
                end else if (!r_op) begin
                    n_res_status = ST_NOT_FOUND;
                    n_state      = S_DONE;
                end else if (r_count == CNT_W'(TABLE_DEPTH)) begin
                    n_res_status = ST_FULL;
                    n_state      = S_DONE;
                end else begin
                    n_i     = r_count;
                    n_pos   = r_lo;
                    n_state = S_SHIFT;
                end
            end
            S_CMP: begin
                if (r_rd_data.key == r_key) begin
                    if (!r_op) begin
                        n_res_status = ST_FOUND;
                        n_res_index  = r_mid;
                        n_res_class  = r_rd_data.cls;
                        n_res_qty    = r_rd_data.qty;
                        n_res_cost   = r_rd_data.cost;
                        n_state      = S_MUL;
                    end else begin
                        n_res_status = ST_DUPLICATE;
                        n_state      = S_DONE;
                    end
                end else begin
                    // narrow the half-open range
                    if (r_key < r_rd_data.key) begin
                        n_hi = CNT_W'(r_mid);
                    end else begin
                        n_lo = CNT_W'(r_mid) + CNT_W'(1);
                    end
                    n_state = S_SRCH;
                end
            end
            S_SHIFT: begin
                if (r_i > r_pos) begin
                    mem_ra  = w_im1[IDX_W-1:0];
                    n_state = S_MOVE;
                end else begin
                    mem_we       = 1'b1;
                    mem_wa       = r_pos[IDX_W-1:0];
                    mem_wd       = '{key: r_key, cls: r_class, qty: r_qty, cost: r_cost};
                    n_count      = r_count + CNT_W'(1);
                    n_res_status = ST_INSERTED;
                    n_res_index  = r_pos[IDX_W-1:0];
                    n_state      = S_DONE;
                end
            end
            S_MOVE: begin
                // move entry i-1 up into slot i
                mem_we  = 1'b1;
                mem_wa  = r_i[IDX_W-1:0];
                mem_wd  = r_rd_data;
                n_i     = w_im1;
                n_state = S_SHIFT;
            end
            S_MUL: begin
                n_res_value = VALUE_W'(r_res_qty) * VALUE_W'(r_res_cost);
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_o_status  = r_res_status;
                    n_o_index   = r_res_index;
                    n_o_class   = r_res_class;
                    n_o_qty     = r_res_qty;
                    n_o_cost    = r_res_cost;
                    n_o_value   = r_res_value;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_i          <= n_i;
        r_pos        <= n_pos;
        r_mid        <= n_mid;
        r_op         <= n_op;
        r_key        <= n_key;
        r_class      <= n_class;
        r_qty        <= n_qty;
        r_cost       <= n_cost;
        r_res_status <= n_res_status;
        r_res_index  <= n_res_index;
        r_res_class  <= n_res_class;
        r_res_qty    <= n_res_qty;
        r_res_cost   <= n_res_cost;
        r_res_value  <= n_res_value;
        r_o_status   <= n_o_status;
        r_o_index    <= n_o_index;
        r_o_class    <= n_o_class;
        r_o_qty      <= n_o_qty;
        r_o_cost     <= n_o_cost;
        r_o_value    <= n_o_value;
    end

    assign w_idx_ext = {{OUT_INDEX_W{1'b0}}, r_o_index};

    assign o_in_stall         = (r_state != S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_status           = r_o_status;
    assign o_found_index      = w_idx_ext[OUT_INDEX_W-1:0];
    assign o_found_class      = r_o_class;
    assign o_found_quantity   = r_o_qty;
    assign o_found_cost_cents = r_o_cost;
    assign o_value_cents      = r_o_value;

    `STLI_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= CNT_W'(TABLE_DEPTH), "record count above table depth")
    `STLI_ASSERT_NOW(a_search_range, i_clk, i_rst_n, r_state == S_SRCH,
        (r_lo <= r_hi) && (r_hi <= r_count), "search range outside valid entries")
    `STLI_ASSERT_NEXT(a_count_hold, i_clk, i_rst_n, r_state != S_SHIFT,
        r_count == $past(r_count), "record count changed outside insert")
    `STLI_ASSERT_NEXT(a_result_kept, i_clk, i_rst_n, r_out_valid && i_out_stall,
        r_out_valid && (r_o_index == $past(r_o_index)), "stalled result overwritten")

endmodule

`default_nettype wire
